/* rtl/core/rmth_pkg.sv */
`timescale 1ns / 1ps
// Package for the running median unit: sizes, types and command codes.
package rmth_pkg;

  localparam int unsigned HeapDepth  = 1024;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned AddrBits   = $clog2(HeapDepth);
  localparam int unsigned SizeBits   = AddrBits + 1;
  localparam int unsigned CountBits  = 12;
  localparam int unsigned MedBits    = SampleBits + 1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [SizeBits-1:0] size_t;

  // Heap operations done by the heap engine.
  typedef enum logic [1:0] {
    OpPush    = 2'd0,  // append value, sift up
    OpReplace = 2'd1,  // overwrite root with value, sift down
    OpPop     = 2'd2   // move last to root, sift down
  } heap_op_e;

  // Command from controller to the heap engine.
  typedef struct packed {
    logic     start;
    logic     sel_upper;  // 0: lower max-heap, 1: upper min-heap
    heap_op_e op;
    sample_t  value;
  } heap_cmd_t;

  // Status from the heap engine back to the controller.
  typedef struct packed {
    logic    busy;
    logic    done;
    size_t   lower_size;
    size_t   upper_size;
    sample_t lower_root;
    sample_t upper_root;
  } heap_sts_t;

  // Returns 1 when a ranks strictly above b in the given heap order.
  function automatic logic ranks_above(sample_t a, sample_t b, logic is_min);
    ranks_above = is_min ? (a < b) : (a > b);
  endfunction

endpackage

/* rtl/core/rmth_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/core/rmth_heap.sv */
`timescale 1ns / 1ps
// Heap engine: two heap RAMs, their sizes, cached roots and a sift sequencer.
module rmth_heap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmth_pkg::heap_cmd_t cmd_i,
  output rmth_pkg::heap_sts_t sts_o
);

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SPopRd = 8'b00000010,
    SUpRd  = 8'b00000100,
    SUpCmp = 8'b00001000,
    SDnRdL = 8'b00010000,
    SDnRdR = 8'b00100000,
    SDnCmp = 8'b01000000,
    SDone  = 8'b10000000
  } heap_state_e;

  heap_state_e state_q, state_d;

  logic                    sel_q, sel_d;
  rmth_pkg::addr_t         idx_q, idx_d;       // position of the moving value
  rmth_pkg::addr_t         chl_q, chl_d;       // left child index
  rmth_pkg::sample_t       val_q, val_d;       // moving value
  rmth_pkg::sample_t       lval_q, lval_d;     // left child value
  logic                    has_r_q, has_r_d;
  rmth_pkg::size_t         n_q, n_d;           // live size during sift down
  rmth_pkg::size_t         lsize_q, lsize_d, usize_q, usize_d;
  rmth_pkg::sample_t       lroot_q, lroot_d, uroot_q, uroot_d;

  logic                    we;
  rmth_pkg::addr_t         addr;
  rmth_pkg::sample_t       wdata;
  logic                    we_l, we_u;
  logic [rmth_pkg::SampleBits-1:0] rd_l, rd_u;
  rmth_pkg::sample_t       rd;

  assign we_l = we & ~sel_q;
  assign we_u = we & sel_q;
  assign rd   = sel_q ? rmth_pkg::sample_t'(rd_u) : rmth_pkg::sample_t'(rd_l);

  rmth_ram #(.Width(rmth_pkg::SampleBits), .Depth(rmth_pkg::HeapDepth)) u_lower (
    .clk_i, .we_i(we_l), .addr_i(addr), .wdata_i(wdata), .rdata_o(rd_l)
  );
  rmth_ram #(.Width(rmth_pkg::SampleBits), .Depth(rmth_pkg::HeapDepth)) u_upper (
    .clk_i, .we_i(we_u), .addr_i(addr), .wdata_i(wdata), .rdata_o(rd_u)
  );

  rmth_pkg::addr_t parent;
  rmth_pkg::size_t l_wide, r_wide;
  logic            is_min;

  assign parent = (idx_q - rmth_pkg::addr_t'(1)) >> 1;
  assign l_wide = {idx_q, 1'b1};
  assign r_wide = l_wide + rmth_pkg::size_t'(1);
  assign is_min = sel_q;

  always_comb begin
    rmth_pkg::sample_t best;
    rmth_pkg::addr_t   best_i;
    state_d = state_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    chl_d   = chl_q;
    val_d   = val_q;
    lval_d  = lval_q;
    has_r_d = has_r_q;
    n_d     = n_q;
    lsize_d = lsize_q;
    usize_d = usize_q;
    lroot_d = lroot_q;
    uroot_d = uroot_q;
    we      = 1'b0;
    addr    = idx_q;
    wdata   = val_q;
    best    = lval_q;
    best_i  = chl_q;
    case (state_q)
      SIdle: begin
        if (cmd_i.start) begin
          sel_d = cmd_i.sel_upper;
          case (cmd_i.op)
            rmth_pkg::OpPush: begin
              // value is written in place when sifting ends
              idx_d = cmd_i.sel_upper ? usize_q[rmth_pkg::AddrBits-1:0]
                                      : lsize_q[rmth_pkg::AddrBits-1:0];
              val_d = cmd_i.value;
              if (cmd_i.sel_upper) usize_d = usize_q + rmth_pkg::size_t'(1);
              else                 lsize_d = lsize_q + rmth_pkg::size_t'(1);
              state_d = SUpRd;
            end
            rmth_pkg::OpReplace: begin
              idx_d = '0;
              val_d = cmd_i.value;
              n_d   = cmd_i.sel_upper ? usize_q : lsize_q;
              state_d = SDnRdL;
            end
            rmth_pkg::OpPop: begin
              // read the last entry, then sift it down from the root
              n_d   = (cmd_i.sel_upper ? usize_q : lsize_q) - rmth_pkg::size_t'(1);
              if (cmd_i.sel_upper) usize_d = usize_q - rmth_pkg::size_t'(1);
              else                 lsize_d = lsize_q - rmth_pkg::size_t'(1);
              idx_d = '0;
              addr  = n_d[rmth_pkg::AddrBits-1:0];
              state_d = SPopRd;
            end
            default: begin
              state_d = SIdle;
            end
          endcase
        end
      end
      SPopRd: begin
        val_d   = rd;
        state_d = SDnRdL;
      end
      SUpRd: begin
        if (idx_q == '0) begin
          we = 1'b1;
          state_d = SDone;
        end else begin
          addr = parent;
          state_d = SUpCmp;
        end
      end
      SUpCmp: begin
        if (rmth_pkg::ranks_above(val_q, rd, is_min)) begin
          we    = 1'b1;
          wdata = rd;
          idx_d = parent;
          state_d = SUpRd;
        end else begin
          we = 1'b1;
          state_d = SDone;
        end
      end
      SDnRdL: begin
        if (l_wide >= n_q) begin
          we = 1'b1;
          state_d = SDone;
        end else begin
          addr    = l_wide[rmth_pkg::AddrBits-1:0];
          chl_d   = l_wide[rmth_pkg::AddrBits-1:0];
          has_r_d = r_wide < n_q;
          state_d = SDnRdR;
        end
      end
      SDnRdR: begin
        // left child data arrives now; issue right child read
        lval_d  = rd;
        addr    = r_wide[rmth_pkg::AddrBits-1:0];
        state_d = SDnCmp;
      end
      SDnCmp: begin
        best   = lval_q;
        best_i = chl_q;
        if (has_r_q && rmth_pkg::ranks_above(rd, lval_q, is_min)) begin
          best   = rd;
          best_i = chl_q + rmth_pkg::addr_t'(1);
        end
        if (rmth_pkg::ranks_above(best, val_q, is_min)) begin
          we    = 1'b1;
          wdata = best;
          idx_d = best_i;
          state_d = SDnRdL;
        end else begin
          we = 1'b1;
          state_d = SDone;
        end
      end
      SDone: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    // root cache follows every write at index zero
    if (we && addr == '0) begin
      if (sel_q) uroot_d = wdata;
      else       lroot_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      lsize_q <= '0;
      usize_q <= '0;
    end else begin
      state_q <= state_d;
      lsize_q <= lsize_d;
      usize_q <= usize_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q   <= sel_d;
    idx_q   <= idx_d;
    chl_q   <= chl_d;
    lval_q  <= lval_d;
    has_r_q <= has_r_d;
    n_q     <= n_d;
    lroot_q <= lroot_d;
    uroot_q <= uroot_d;
    val_q   <= val_d;
  end

  assign sts_o.busy       = (state_q != SIdle);
  assign sts_o.done       = (state_q == SDone);
  assign sts_o.lower_size = lsize_q;
  assign sts_o.upper_size = usize_q;
  assign sts_o.lower_root = lroot_q;
  assign sts_o.upper_root = uroot_q;

`ifndef SYNTHESIS
  a_size_l: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lsize_q <= rmth_pkg::size_t'(rmth_pkg::HeapDepth)) else $error("lower heap overflow");
  a_size_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    usize_q <= rmth_pkg::size_t'(rmth_pkg::HeapDepth)) else $error("upper heap overflow");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone |=> state_q == SIdle) else $error("done not followed by idle");
`endif

endmodule

/* rtl/core/rmth_ctrl.sv */
`timescale 1ns / 1ps
// Controller: decides heap operations per sample and forms the result.
module rmth_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  rmth_pkg::sample_t   sample_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [rmth_pkg::MedBits-1:0]   med_o,
  output logic [rmth_pkg::CountBits-1:0] count_o,
  output logic                dropped_o,
  output rmth_pkg::heap_cmd_t cmd_o,
  input  rmth_pkg::heap_sts_t sts_i
);

  typedef enum logic [5:0] {
    CIdle  = 6'b000001,
    CFirst = 6'b000010,
    CWait1 = 6'b000100,
    CSecnd = 6'b001000,
    CBal   = 6'b010000,
    COut   = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  rmth_pkg::sample_t x_q, x_d, old_q, old_d;
  logic              need2_q, need2_d, sel2_q, sel2_d;
  logic              ovld_q, ovld_d;
  logic [rmth_pkg::MedBits-1:0]   med_q, med_d;
  logic [rmth_pkg::CountBits-1:0] cnt_q, cnt_d;
  logic              drop_q, drop_d;

  rmth_pkg::size_t ls, us;
  logic [rmth_pkg::SizeBits:0] total;
  logic full_l, full_u, take;

  assign ls = sts_i.lower_size;
  assign us = sts_i.upper_size;
  assign total  = {1'b0, ls} + {1'b0, us};
  assign full_l = ls == rmth_pkg::size_t'(rmth_pkg::HeapDepth);
  assign full_u = us == rmth_pkg::size_t'(rmth_pkg::HeapDepth);
  // a waiting result only holds COut, so intake stays open while it waits
  assign s_tready_o = (state_q == CIdle);
  assign take = s_tvalid_i && s_tready_o;

  always_comb begin
    logic signed [rmth_pkg::MedBits-1:0] lr, ur;
    state_d = state_q;
    x_d = x_q; old_d = old_q; need2_d = need2_q; sel2_d = sel2_q;
    ovld_d = ovld_q; med_d = med_q; cnt_d = cnt_q; drop_d = drop_q;
    cmd_o = '0;
    lr = rmth_pkg::MedBits'(sts_i.lower_root);
    ur = rmth_pkg::MedBits'(sts_i.upper_root);
    if (ovld_q && m_tready_i) ovld_d = 1'b0;
    case (state_q)
      CIdle: begin
        if (take) begin
          x_d = sample_i;
          state_d = CFirst;
        end
      end
      CFirst: begin
        need2_d = 1'b0;
        drop_d  = 1'b0;
        cmd_o.start = 1'b1;
        cmd_o.value = x_q;
        state_d = CWait1;
        if (total >= (rmth_pkg::SizeBits+1)'(2 * rmth_pkg::HeapDepth)) begin
          drop_d = 1'b1;
          cmd_o.start = 1'b0;
          state_d = COut;
        end else if (ls == '0 || x_q < sts_i.lower_root) begin
          if (!full_l) begin
            cmd_o.op = rmth_pkg::OpPush;
          end else begin
            cmd_o.op = rmth_pkg::OpReplace;
            old_d = sts_i.lower_root;
            need2_d = 1'b1; sel2_d = 1'b1;
          end
        end else begin
          cmd_o.sel_upper = 1'b1;
          if (!full_u) begin
            cmd_o.op = rmth_pkg::OpPush;
          end else if (x_q <= sts_i.upper_root) begin
            cmd_o.sel_upper = 1'b0;
            cmd_o.op = rmth_pkg::OpPush;
          end else begin
            cmd_o.op = rmth_pkg::OpReplace;
            old_d = sts_i.upper_root;
            need2_d = 1'b1; sel2_d = 1'b0;
          end
        end
      end
      CWait1: begin
        if (!sts_i.busy) begin
          state_d = need2_q ? CSecnd : CBal;
        end
      end
      CSecnd: begin
        // pending root move or rebalance transfer: push into other heap
        cmd_o.start = 1'b1;
        cmd_o.op = rmth_pkg::OpPush;
        cmd_o.sel_upper = sel2_q;
        cmd_o.value = old_q;
        need2_d = 1'b0;
        state_d = CWait1;
      end
      CBal: begin
        if (ls > us + rmth_pkg::size_t'(1)) begin
          old_d = sts_i.lower_root;
          cmd_o.start = 1'b1; cmd_o.op = rmth_pkg::OpPop; cmd_o.sel_upper = 1'b0;
          need2_d = 1'b1; sel2_d = 1'b1;
          state_d = CWait1;
        end else if (us > ls + rmth_pkg::size_t'(1)) begin
          old_d = sts_i.upper_root;
          cmd_o.start = 1'b1; cmd_o.op = rmth_pkg::OpPop; cmd_o.sel_upper = 1'b1;
          need2_d = 1'b1; sel2_d = 1'b0;
          state_d = CWait1;
        end else begin
          state_d = COut;
        end
      end
      COut: begin
        if (!ovld_q || m_tready_i) begin
          if (ls == '0 && us == '0) med_d = '0;
          else if (ls == us) med_d = lr + ur;
          else if (ls > us)  med_d = lr <<< 1;
          else               med_d = ur <<< 1;
          cnt_d = rmth_pkg::CountBits'(total);
          ovld_d = 1'b1;
          state_d = CIdle;
        end
      end
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      ovld_q  <= 1'b0;
      need2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      need2_q <= need2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; old_q <= old_d; sel2_q <= sel2_d;
    med_q <= med_d; cnt_q <= cnt_d; drop_q <= drop_d;
  end

  assign m_tvalid_o = ovld_q;
  assign med_o      = med_q;
  assign count_o    = cnt_q;
  assign dropped_o  = drop_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_tready_i |=> ovld_q) else $error("result lost under stall");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> state_q == CIdle) else $error("accept outside idle");
  a_bal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == COut |-> (ls <= us + rmth_pkg::size_t'(1)) && (us <= ls + rmth_pkg::size_t'(1)))
    else $error("heaps unbalanced at output");
`endif

endmodule

/* rtl/core/running_median_two_heaps_unit.sv */
`timescale 1ns / 1ps
// Top level of the running median unit.
// Input stream: s_axis carries one signed 32-bit sample per transaction.
// Output stream: m_axis carries one result per accepted sample:
//   twice the median of all stored samples, the stored count and a drop flag.
// The lower half sits in a max-heap RAM, the upper half in a min-heap RAM,
// both 1024 deep; one heap engine walks them with a single RAM port each.
// Latency is data dependent: each sift-up level passes the states SUpRd and
// SUpCmp, each sift-down level SDnRdL, SDnRdR and SDnCmp, plus SDone and the
// controller wait state per heap operation. A dropped sample never enters the
// heap engine; the longest case is a push, a rebalance pop and a push that all walk a full depth.
// One sample is processed at a time; the input is ready again in the cycle the
// result appears. A result waits in an output register; the next sample may be
// accepted while it waits, and processing stalls only when a new result would
// overwrite it.
// Reset empties both heaps at once (sizes cleared); no clearing pass is run.
// When the store holds 2048 samples further samples are dropped and flagged.
module running_median_two_heaps_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [32:0] median_times_two, [44:33] stored_count
  output logic        m_axis_tuser    // dropped
);

  rmth_pkg::heap_cmd_t cmd;
  rmth_pkg::heap_sts_t sts;
  logic [rmth_pkg::MedBits-1:0]   med;
  logic [rmth_pkg::CountBits-1:0] cnt;

  rmth_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .sample_i(rmth_pkg::sample_t'(s_axis_tdata)),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .med_o(med), .count_o(cnt), .dropped_o(m_axis_tuser),
    .cmd_o(cmd), .sts_i(sts)
  );

  rmth_heap u_heap (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts));

  assign m_axis_tdata = {3'b000, cnt, med};

endmodule
